// ===== hw/rtl/dqpm_pkg.sv =====
// Shared types and codes for the deque with pop-max block.
package dqpm_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_MAX    = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_PEEK_FRONT = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } rsp_t;

endpackage

// ===== hw/rtl/dqpm_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
module dqpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/deque_with_pop_max_core.sv =====
// Top level: deque with pop-max, state kept in one synchronous RAM.
//
// Requests arrive on s_ (opcode, value_in) with valid/ready; each request
// gives exactly one response on m_ (value_out, status, occupancy).
// One request is handled at a time.
// Pushes, no-ops and empty or full refusals give response valid in the cycle
// after the transfer (the push writes the RAM at the accepting edge).
// Pops and peeks pass through address, RAM read and result steps.
// Pop max runs a scan that reads every stored word one per cycle through the
// single RAM read port to find the first maximum, then a compaction pass
// moves each later word one slot toward the front, one read and one write
// per cycle.
// s_ready returns in the cycle after the response transfer, so even with a
// ready receiver a push waits for the previous response to be taken.
// The response sits in an output register; s_ready stays low until the
// response has been transferred, so a stalled receiver holds the block.
// Reset (aresetn low, synchronous) empties the deque: head and count clear,
// the RAM contents are left as they are and never read before written.
module deque_with_pop_max_core #(
    parameter int DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dqpm_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dqpm_pkg::rsp_t  m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DONE, S_SCAN, S_MOVE, S_RESP
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    dqpm_pkg::opcode_t op_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     best_reg;
    logic signed [31:0] bestv_reg;
    logic              scan_vld_reg;
    // read of the word after the maximum is in flight
    logic              best_rd_ok;
    logic [CW-1:0]     rd_pos_reg;
    dqpm_pkg::rsp_t    rsp_reg;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [31:0]       wdata, rdata;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [CW:0] s;
        begin
            s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
            if (s >= (CW+1)'(DEPTH)) begin
                s = s - (CW+1)'(DEPTH);
            end
            slot = s[AW-1:0];
        end
    endfunction

    dqpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);
    assign m_data  = rsp_reg;

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // RAM control
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = s_data.value_in;
        raddr = slot(head_reg, rd_pos_reg);
        if (s_xfer && count_reg != CW'(DEPTH)) begin
            if (s_data.opcode == dqpm_pkg::OP_PUSH_BACK) begin
                we    = 1'b1;
                waddr = slot(head_reg, count_reg);
            end else if (s_data.opcode == dqpm_pkg::OP_PUSH_FRONT) begin
                we    = 1'b1;
                waddr = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
            end
        end
        if (state_reg == S_MOVE && scan_vld_reg) begin
            // rdata holds word at idx_reg+1; store it at idx_reg
            we    = 1'b1;
            waddr = slot(head_reg, idx_reg);
            wdata = rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            scan_vld_reg <= 1'b0;
            best_rd_ok   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        op_reg            <= s_data.opcode;
                        rsp_reg.value_out <= '0;
                        case (s_data.opcode)
                            dqpm_pkg::OP_PUSH_BACK, dqpm_pkg::OP_PUSH_FRONT: begin
                                state_reg <= S_RESP;
                                if (count_reg == CW'(DEPTH)) begin
                                    rsp_reg.status    <= dqpm_pkg::ST_FULL;
                                    rsp_reg.occupancy <= 5'(count_reg);
                                end else begin
                                    rsp_reg.status    <= dqpm_pkg::ST_OK;
                                    count_reg         <= count_reg + 1'b1;
                                    rsp_reg.occupancy <= 5'(count_reg + 1'b1);
                                    if (s_data.opcode == dqpm_pkg::OP_PUSH_FRONT) begin
                                        head_reg <= (head_reg == '0) ?
                                            AW'(DEPTH - 1) : head_reg - 1'b1;
                                    end
                                end
                            end
                            dqpm_pkg::OP_NOP: begin
                                rsp_reg.status    <= dqpm_pkg::ST_OK;
                                rsp_reg.occupancy <= 5'(count_reg);
                                state_reg         <= S_RESP;
                            end
                            default: begin
                                rsp_reg.occupancy <= 5'(count_reg);
                                if (count_reg == '0) begin
                                    rsp_reg.status <= dqpm_pkg::ST_EMPTY;
                                    state_reg <= S_RESP;
                                end else begin
                                    rsp_reg.status <= dqpm_pkg::ST_OK;
                                    if (s_data.opcode == dqpm_pkg::OP_POP_MAX) begin
                                        rd_pos_reg   <= '0;
                                        idx_reg      <= '0;
                                        scan_vld_reg <= 1'b0;
                                        state_reg    <= S_SCAN;
                                    end else begin
                                        if (s_data.opcode == dqpm_pkg::OP_POP_BACK ||
                                            s_data.opcode == dqpm_pkg::OP_PEEK_BACK) begin
                                            rd_pos_reg <= count_reg - 1'b1;
                                        end else begin
                                            rd_pos_reg <= '0;
                                        end
                                        state_reg <= S_READ;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    rsp_reg.value_out <= rdata;
                    if (op_reg == dqpm_pkg::OP_POP_BACK) begin
                        count_reg <= count_reg - 1'b1;
                        rsp_reg.occupancy <= 5'(count_reg - 1'b1);
                    end else if (op_reg == dqpm_pkg::OP_POP_FRONT) begin
                        count_reg <= count_reg - 1'b1;
                        rsp_reg.occupancy <= 5'(count_reg - 1'b1);
                        head_reg <= slot(head_reg, CW'(1));
                    end
                    state_reg <= S_RESP;
                end
                S_SCAN: begin
                    // rd_pos issues reads; scan_vld marks rdata as word idx_reg
                    if (rd_pos_reg < count_reg) begin
                        rd_pos_reg <= rd_pos_reg + 1'b1;
                    end
                    scan_vld_reg <= (rd_pos_reg < count_reg);
                    if (scan_vld_reg) begin
                        if (idx_reg == '0 || $signed(rdata) > bestv_reg) begin
                            bestv_reg <= $signed(rdata);
                            best_reg  <= idx_reg;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == count_reg) begin
                            state_reg <= S_MOVE;
                        end
                    end
                end
                S_MOVE: begin
                    if (scan_vld_reg) begin
                        // write lands at idx_reg; read two ahead of it
                        idx_reg    <= idx_reg + 1'b1;
                        rd_pos_reg <= rd_pos_reg + 1'b1;
                        if (idx_reg + 2'd2 >= count_reg) begin
                            scan_vld_reg      <= 1'b0;
                            best_rd_ok        <= 1'b0;
                            count_reg         <= count_reg - 1'b1;
                            rsp_reg.occupancy <= 5'(count_reg - 1'b1);
                            state_reg         <= S_RESP;
                        end
                    end else if (best_rd_ok) begin
                        rd_pos_reg   <= rd_pos_reg + 1'b1;
                        scan_vld_reg <= 1'b1;
                    end else begin
                        rsp_reg.value_out <= bestv_reg;
                        idx_reg    <= best_reg;
                        rd_pos_reg <= best_reg + 1'b1;
                        if (best_reg + 1'b1 < count_reg) begin
                            best_rd_ok <= 1'b1;
                        end else begin
                            count_reg <= count_reg - 1'b1;
                            rsp_reg.occupancy <= 5'(count_reg - 1'b1);
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready) else $error("accepted while busy");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("count overflow");
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("response lost");
`endif

endmodule
